// File: rtl/msgsp_pkg.sv
// ----------------------------------------------------------------------------
// msgsp_pkg
// Shared codes, widths and types of the multistage graph shortest path engine.
// ----------------------------------------------------------------------------
package msgsp_pkg;

  // Port widths fixed by the command format
  localparam int OPCODE_W    = 2;
  localparam int VERTEX_W    = 4;
  localparam int WEIGHT_IN_W = 16;
  localparam int STAGE_W     = 5;
  localparam int STATUS_W    = 2;
  localparam int VCOUNT_W    = 5;
  localparam int CFG_W       = 16;

  // Path cost arithmetic saturates at the all-ones code
  localparam int               COST_W   = 20;
  localparam logic [COST_W-1:0] COST_MAX = 20'hFFFFF;

  // Command opcodes
  localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_EXIST  = 2'd2;
  localparam logic [OPCODE_W-1:0] OP_SOLVE  = 2'd3;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ERR  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DUP  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOTP = 2'd3;

  // Configuration register indexes
  localparam logic REG_VERTEX_COUNT = 1'b0;
  localparam logic REG_NO_EDGE      = 1'b1;

  // Control of the shared relaxation unit
  typedef struct packed {
    logic clear;  // restart the running minimum
    logic valid;  // a candidate edge beat is on the data inputs
  } relax_ctrl_t;

endpackage

// File: rtl/msgsp_ram.sv
// ----------------------------------------------------------------------------
// msgsp_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module msgsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/msgsp_relax.sv
// ----------------------------------------------------------------------------
// msgsp_relax
// Shared add, saturate and compare unit: keeps the running least cost and
// its predecessor while the predecessors of one vertex stream through.
// ----------------------------------------------------------------------------
module msgsp_relax
  import msgsp_pkg::*;
#(
  parameter int WEIGHT_BITS = 16,
  parameter int VW          = 4
) (
  input  logic                   clk,
  input  relax_ctrl_t            ctrl,
  input  logic                   present,
  input  logic [WEIGHT_BITS-1:0] weight,
  input  logic [COST_W-1:0]      cost,
  input  logic [VW-1:0]          index,
  output logic [COST_W-1:0]      best_upd,
  output logic [VW-1:0]          pred_upd
);

  localparam int SW = ((COST_W > WEIGHT_BITS) ? COST_W : WEIGHT_BITS) + 1;

  logic [COST_W-1:0] best;
  logic [VW-1:0]     pred;
  logic [SW-1:0]     sum;
  logic [COST_W-1:0] cand;
  logic              take;

  always_comb begin
    sum  = SW'(cost) + SW'(weight);
    cand = (sum > SW'(COST_MAX)) ? COST_MAX : COST_W'(sum);
    // strict less-than keeps the smallest predecessor on ties
    take = ctrl.valid && present && (weight != '0) && (cand < best);
    best_upd = take ? cand : best;
    pred_upd = take ? index : pred;
  end

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      best <= COST_MAX;
      pred <= '0;
    end else begin
      best <= best_upd;
      pred <= pred_upd;
    end
  end

endmodule

// File: rtl/multistage_graph_shortest_path_top.sv
// ----------------------------------------------------------------------------
// multistage_graph_shortest_path_top
// Edge edit commands and a forward dynamic-programming solve over a stored
// adjacency matrix, with a traced path emitted one vertex per beat.
// ----------------------------------------------------------------------------
// Edge commands pass through the EDGE_RD and EDGE_ACT states before a registered
// result; a rejected command answers in the next cycle. A solve reads the weight
// RAM once per predecessor through the shared relaxation unit, and busy stays
// high throughout. Results are one-cycle beats; the receiver cannot stall. After
// reset a clearing pass over every weight RAM address empties the matrix.
module multistage_graph_shortest_path_top
  import msgsp_pkg::*;
#(
  parameter int MAX_VERTICES = 16,
  parameter int WEIGHT_BITS  = 16
) (
  input  logic                clk,
  input  logic                rst,
  // configuration
  input  logic                cfg_write,
  input  logic                cfg_index,
  input  logic [CFG_W-1:0]    cfg_data,
  // command
  input  logic                start,
  output logic                busy,
  input  logic [OPCODE_W-1:0] opcode,
  input  logic [VERTEX_W-1:0] from_vertex,
  input  logic [VERTEX_W-1:0] to_vertex,
  input  logic [WEIGHT_IN_W-1:0] edge_weight,
  input  logic [STAGE_W-1:0]  stage_count,
  // results
  output logic                result_valid,
  output logic [STATUS_W-1:0] status,
  output logic [VERTEX_W-1:0] path_vertex,
  output logic [COST_W-1:0]   total_cost,
  output logic                last
);

  localparam int VW     = $clog2(MAX_VERTICES);
  localparam int AW     = 2 * VW;
  localparam int WDEPTH = 1 << AW;
  localparam int NB     = $clog2(MAX_VERTICES + 1);
  localparam int CNTW   = (NB > VCOUNT_W) ? NB : VCOUNT_W;

  localparam logic [3:0] S_CLEAR    = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_EDGE_RD  = 4'd2;
  localparam logic [3:0] S_EDGE_ACT = 4'd3;
  localparam logic [3:0] S_INIT     = 4'd4;
  localparam logic [3:0] S_SCAN     = 4'd5;
  localparam logic [3:0] S_LAST     = 4'd6;
  localparam logic [3:0] S_TR_WR    = 4'd7;
  localparam logic [3:0] S_TR_WAIT  = 4'd8;
  localparam logic [3:0] S_OUT      = 4'd9;
  localparam logic [3:0] S_DRAIN    = 4'd10;

  // configuration registers
  logic [VCOUNT_W-1:0] vertex_count;
  logic [CFG_W-1:0]    no_edge_value;

  // sequencer registers
  logic [3:0]             state;
  logic [AW-1:0]          clr_addr;
  logic [OPCODE_W-1:0]    op_q;
  logic [VW-1:0]          u_q, v_q;
  logic [WEIGHT_BITS-1:0] w_q;
  logic [VW-1:0]          nm1, km1;
  logic [VW-1:0]          j, i, rd_i;
  logic                   rd_valid;
  logic [VW-1:0]          cur, pos, o, o_q;
  logic                   ov;
  logic [COST_W-1:0]      final_cost;

  // memory ports
  logic                   w_we;
  logic [AW-1:0]          w_waddr, w_raddr;
  logic [WEIGHT_BITS:0]   w_wdata, w_rdata;
  logic                   c_we;
  logic [VW-1:0]          c_waddr;
  logic [COST_W-1:0]      c_wdata;
  logic [VW-1:0]          p_wdata;
  logic [COST_W-1:0]      c_rdata;
  logic [VW-1:0]          p_rdata;
  logic                   pb_we;
  logic [VW-1:0]          pb_rdata;

  // relaxation unit
  relax_ctrl_t            rctrl;
  logic [COST_W-1:0]      best_upd;
  logic [VW-1:0]          pred_upd;

  // decode
  logic [CNTW-1:0]        vc_ext, n_live, u_ext, v_ext, k_ext;
  logic                   accept, edge_bad, stage_bad, pres;
  logic [WEIGHT_BITS-1:0] w_in, noedge;

  // result next values
  logic                   res_valid_next;
  logic [STATUS_W-1:0]    status_next;
  logic [VERTEX_W-1:0]    path_vertex_next;
  logic [COST_W-1:0]      total_cost_next;
  logic                   last_next;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  always_comb begin
    vc_ext = CNTW'(vertex_count);
    if (vc_ext < CNTW'(2)) begin
      n_live = CNTW'(2);
    end else if (vc_ext > CNTW'(MAX_VERTICES)) begin
      n_live = CNTW'(MAX_VERTICES);
    end else begin
      n_live = vc_ext;
    end
    u_ext     = CNTW'(from_vertex);
    v_ext     = CNTW'(to_vertex);
    k_ext     = CNTW'(stage_count);
    edge_bad  = (u_ext >= n_live) || (v_ext >= n_live) || (from_vertex == to_vertex);
    stage_bad = (k_ext < CNTW'(2)) || (k_ext > n_live);
    w_in      = WEIGHT_BITS'(edge_weight);
    noedge    = WEIGHT_BITS'(no_edge_value);
    pres      = w_rdata[WEIGHT_BITS];
  end

  // memory port steering
  always_comb begin
    w_we    = 1'b0;
    w_waddr = {u_q, v_q};
    w_wdata = {1'b1, w_q};
    if (state == S_CLEAR) begin
      w_we    = 1'b1;
      w_waddr = clr_addr;
      w_wdata = '0;
    end else if (state == S_EDGE_ACT) begin
      if (op_q == OP_INSERT) begin
        w_we = !pres && (w_q != noedge);
      end else if (op_q == OP_REMOVE) begin
        w_we    = pres;
        w_wdata = {1'b0, w_q};
      end
    end
    w_raddr = (state == S_SCAN) ? {i, j} : {u_q, v_q};
    c_we    = (state == S_INIT) || (state == S_LAST);
    c_waddr = (state == S_INIT) ? '0 : j;
    // vertex 0 starts the recurrence at zero cost with predecessor 0
    c_wdata = (state == S_INIT) ? '0 : best_upd;
    p_wdata = (state == S_INIT) ? '0 : pred_upd;
    pb_we   = (state == S_TR_WR);
    rctrl.clear = (state == S_INIT) || (state == S_LAST);
    rctrl.valid = rd_valid;
  end

  msgsp_ram #(.WIDTH(WEIGHT_BITS + 1), .DEPTH(WDEPTH)) u_weight_ram (
    .clk   (clk),
    .we    (w_we),
    .waddr (w_waddr),
    .wdata (w_wdata),
    .raddr (w_raddr),
    .rdata (w_rdata)
  );

  msgsp_ram #(.WIDTH(COST_W), .DEPTH(MAX_VERTICES)) u_cost_ram (
    .clk   (clk),
    .we    (c_we),
    .waddr (c_waddr),
    .wdata (c_wdata),
    .raddr (i),
    .rdata (c_rdata)
  );

  msgsp_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_pred_ram (
    .clk   (clk),
    .we    (c_we),
    .waddr (c_waddr),
    .wdata (p_wdata),
    .raddr (cur),
    .rdata (p_rdata)
  );

  msgsp_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_path_ram (
    .clk   (clk),
    .we    (pb_we),
    .waddr (pos),
    .wdata (cur),
    .raddr (o),
    .rdata (pb_rdata)
  );

  msgsp_relax #(.WEIGHT_BITS(WEIGHT_BITS), .VW(VW)) u_relax (
    .clk      (clk),
    .ctrl     (rctrl),
    .present  (pres),
    .weight   (w_rdata[WEIGHT_BITS-1:0]),
    .cost     (c_rdata),
    .index    (rd_i),
    .best_upd (best_upd),
    .pred_upd (pred_upd)
  );

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count  <= VCOUNT_W'(16);
      no_edge_value <= CFG_W'(999);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_VERTEX_COUNT: vertex_count  <= cfg_data[VCOUNT_W-1:0];
        REG_NO_EDGE:      no_edge_value <= cfg_data;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      rd_valid <= 1'b0;
      ov       <= 1'b0;
    end else begin
      rd_valid <= (state == S_SCAN);
      ov       <= (state == S_OUT);
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == '1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            op_q <= opcode;
            u_q  <= VW'(from_vertex);
            v_q  <= VW'(to_vertex);
            w_q  <= w_in;
            nm1  <= VW'(n_live - 1'b1);
            km1  <= VW'(k_ext - 1'b1);
            if (opcode == OP_SOLVE) begin
              if (!stage_bad) begin
                state <= S_INIT;
              end
            end else if (!edge_bad) begin
              state <= S_EDGE_RD;
            end
          end
        end
        S_EDGE_RD:  state <= S_EDGE_ACT;
        S_EDGE_ACT: state <= S_IDLE;
        S_INIT: begin
          j     <= VW'(1);
          i     <= '0;
          state <= S_SCAN;
        end
        S_SCAN: begin
          rd_i <= i;
          if (i == VW'(j - 1'b1)) begin
            state <= S_LAST;
          end else begin
            i <= i + 1'b1;
          end
        end
        S_LAST: begin
          if (j == nm1) begin
            final_cost <= best_upd;
            cur        <= nm1;
            pos        <= km1;
            state      <= S_TR_WR;
          end else begin
            j     <= j + 1'b1;
            i     <= '0;
            state <= S_SCAN;
          end
        end
        S_TR_WR: begin
          // the first path vertex is always vertex 0 and is not stored
          if (pos == VW'(1)) begin
            o     <= '0;
            state <= S_OUT;
          end else begin
            pos   <= pos - 1'b1;
            state <= S_TR_WAIT;
          end
        end
        S_TR_WAIT: begin
          cur   <= p_rdata;
          state <= S_TR_WR;
        end
        S_OUT: begin
          o_q <= o;
          if (o == km1) begin
            state <= S_DRAIN;
          end else begin
            o <= o + 1'b1;
          end
        end
        S_DRAIN: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // result beat
  always_comb begin
    res_valid_next   = 1'b0;
    status_next      = ST_OK;
    path_vertex_next = '0;
    total_cost_next  = '0;
    last_next        = 1'b1;
    if (ov) begin
      res_valid_next   = 1'b1;
      path_vertex_next = (o_q == '0) ? '0 : VERTEX_W'(pb_rdata);
      last_next        = (o_q == km1);
      total_cost_next  = last_next ? final_cost : '0;
    end else if (accept && ((opcode == OP_SOLVE) ? stage_bad : edge_bad)) begin
      res_valid_next = 1'b1;
      status_next    = ST_ERR;
    end else if (state == S_EDGE_ACT) begin
      res_valid_next = 1'b1;
      case (op_q)
        OP_INSERT: status_next = pres ? ST_DUP : ST_OK;
        OP_REMOVE: status_next = pres ? ST_OK : ST_NOTP;
        OP_EXIST:  status_next = pres ? ST_OK : ST_ERR;
        default:   status_next = ST_ERR;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= res_valid_next;
    end
    status      <= status_next;
    path_vertex <= path_vertex_next;
    total_cost  <= total_cost_next;
    last        <= last_next;
  end

endmodule
